// ===== rtl/core/sliding_window_median_assert.svh =====
// Assertion macros shared by the running-median RTL.
`ifndef SLIDING_WINDOW_MEDIAN_ASSERT_SVH
`define SLIDING_WINDOW_MEDIAN_ASSERT_SVH

// Check a property at every clock edge outside reset.
`define SWM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition in a cycle implies another in the next cycle.
`define SWM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/swm_pkg.sv =====
// Shared constants, types and helper functions of the running-median filter.
package swm_pkg;

	localparam int MAX_WINDOW = 64;
	localparam int DATA_WIDTH = 32;
	localparam int CFG_W      = 7;
	localparam int IDX_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int AGE_W      = IDX_W;
	localparam int LVL_N      = IDX_W;

	localparam logic [CFG_W-1:0] WIN_RESET = CFG_W'(3);

	// One sorted slot of the window
	typedef struct packed {
		logic                  valid;
		logic [AGE_W-1:0]      age;
		logic [DATA_WIDTH-1:0] value;
	} swm_entry_t;

	// What a cell sees of its neighbor
	typedef struct packed {
		swm_entry_t entry;
		logic       gt;
		logic       past_del;
	} swm_link_t;

	// Broadcast from the controller to every cell
	typedef struct packed {
		logic                  step;
		logic                  clear;
		logic                  del_en;
		logic [AGE_W-1:0]      del_age;
		logic [DATA_WIDTH-1:0] sample;
	} swm_ctrl_t;

	// Window length minus one, with zero read as one and large values saturated
	function automatic logic [IDX_W-1:0] swm_km1(input logic [CFG_W-1:0] w);
		logic [IDX_W-1:0] r;
		if (w == '0) begin
			r = '0;
		end else if (int'(w) > MAX_WINDOW) begin
			r = IDX_W'(MAX_WINDOW - 1);
		end else begin
			r = IDX_W'(w - CFG_W'(1));
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/swm_cell.sv =====
// One cell of the sorted chain: holds a value with its age and shifts with its neighbors.
module swm_cell
	import swm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  swm_ctrl_t             ctrl,
	input  swm_link_t             left,
	input  swm_link_t             right,
	input  logic                  past_del,
	output swm_entry_t            entry,
	output logic                  gt,
	output logic                  hit,
	output logic [DATA_WIDTH-1:0] cand
);

	logic                  valid_q;
	logic [AGE_W-1:0]      age_q;
	logic [DATA_WIDTH-1:0] value_q;

	swm_entry_t own_e;
	swm_entry_t left_e;
	logic       own_gte;
	logic       left_gte;
	swm_entry_t nxt;

	assign entry = '{valid: valid_q, age: age_q, value: value_q};

	// Empty slots sort above every sample
	assign gt  = !valid_q || (value_q > ctrl.sample);
	assign hit = ctrl.del_en && valid_q && (age_q == ctrl.del_age);

	// Value this slot would hold with the sample inserted and nothing removed
	always_comb begin
		if (!gt) begin
			cand = value_q;
		end else if (!left.gt) begin
			cand = ctrl.sample;
		end else begin
			cand = left.entry.value;
		end
	end

	// Close the gap of the removed entry, then open one for the new sample
	always_comb begin
		own_e    = past_del ? right.entry : entry;
		own_gte  = past_del ? right.gt : gt;
		left_e   = left.past_del ? entry : left.entry;
		left_gte = left.past_del ? gt : left.gt;
		if (!own_gte) begin
			nxt     = own_e;
			nxt.age = own_e.age + AGE_W'(1);
		end else if (!left_gte) begin
			nxt = '{valid: 1'b1, age: '0, value: ctrl.sample};
		end else begin
			nxt     = left_e;
			nxt.age = left_e.age + AGE_W'(1);
		end
	end

	// Occupancy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.clear) begin
			valid_q <= 1'b0;
		end else if (ctrl.step) begin
			valid_q <= nxt.valid;
		end
	end

	// Value and age advance on every step
	always_ff @(posedge clk) begin
		if (ctrl.step) begin
			age_q   <= nxt.age;
			value_q <= nxt.value;
		end
	end

endmodule

// ===== rtl/core/sliding_window_median.sv =====
// Top level of the running-median filter: controller, cell chain and output register.
//
// Use: samples arrive on in_valid/in_ready/sample, medians leave on
// out_valid/out_ready/median, and the window length is written on
// cfg_valid/cfg_ready/window_size (cfg_ready is always high).
// A length of zero acts as one; lengths above 64 act as 64.
// The window is a chain of 64 cells kept in ascending order. Each accepted
// sample is inserted and, once the window is full, the oldest is removed in
// the same cycle, so one sample is taken each clock cycle that in_ready is high.
// Each sample that completes a full window yields the lower median in the cycle
// after acceptance, held in an output register until taken.
// After reset or a length write, the first (length in use) - 1 samples give no
// result. Reset sets the length to 3 and empties the window; a length write
// empties it as well. No clearing pass is needed: every cell has its own
// occupancy flag.
// When the receiver stalls with a median waiting, a sample that would give a
// result waits; a sample that gives none is still accepted.
// A length write holds off the sample side for that cycle.
module sliding_window_median
	import swm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_W-1:0]      window_size,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [DATA_WIDTH-1:0] sample,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [DATA_WIDTH-1:0] median
);

	logic [IDX_W-1:0]      km1_q;
	logic [IDX_W-1:0]      fill_q;
	logic                  out_valid_q;
	logic [DATA_WIDTH-1:0] median_q;

	logic                  cfg_fire;
	logic                  accept;
	logic                  full;
	logic                  single;
	logic [IDX_W-1:0]      mid;
	swm_ctrl_t             ctrl;

	swm_entry_t            entry    [MAX_WINDOW];
	logic [DATA_WIDTH-1:0] cand     [MAX_WINDOW];
	logic [MAX_WINDOW-1:0] gt_vec;
	logic [MAX_WINDOW-1:0] hit_vec;
	logic [MAX_WINDOW-1:0] past_vec;
	logic [MAX_WINDOW-1:0] valid_vec;
	logic [MAX_WINDOW-1:0] pre      [LVL_N+1];
	logic [DATA_WIDTH-1:0] med_sel;

	// Handshakes
	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign full      = (fill_q == km1_q);
	assign single    = (km1_q == '0);
	assign mid       = km1_q >> 1;
	assign in_ready  = !cfg_fire && (!out_valid_q || out_ready || !full);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign median    = median_q;

	// Broadcast to the chain; a one-sample window leaves the chain empty
	assign ctrl = '{
		step:    accept && !single && !cfg_fire,
		clear:   cfg_fire,
		del_en:  full,
		del_age: km1_q - IDX_W'(1),
		sample:  sample
	};

	// Mark every cell at or after the removed one (log-depth prefix OR)
	always_comb begin
		pre[0] = hit_vec;
		for (int l = 0; l < LVL_N; l++) begin
			for (int i = 0; i < MAX_WINDOW; i++) begin
				if (i >= (1 << l)) begin
					pre[l+1][i] = pre[l][i] | pre[l][i-(1<<l)];
				end else begin
					pre[l+1][i] = pre[l][i];
				end
			end
		end
		past_vec = pre[LVL_N];
	end

	// Cell chain
	for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
		swm_link_t lnk_l;
		swm_link_t lnk_r;

		if (g == 0) begin : g_head
			assign lnk_l = '{entry: '0, gt: 1'b0, past_del: 1'b0};
		end else begin : g_mid
			assign lnk_l = '{entry: entry[g-1], gt: gt_vec[g-1], past_del: past_vec[g-1]};
		end

		if (g == MAX_WINDOW - 1) begin : g_tail
			assign lnk_r = '{entry: '0, gt: 1'b1, past_del: 1'b1};
		end else begin : g_body
			assign lnk_r = '{entry: entry[g+1], gt: gt_vec[g+1], past_del: past_vec[g+1]};
		end

		swm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.left     (lnk_l),
			.right    (lnk_r),
			.past_del (past_vec[g]),
			.entry    (entry[g]),
			.gt       (gt_vec[g]),
			.hit      (hit_vec[g]),
			.cand     (cand[g])
		);

		assign valid_vec[g] = entry[g].valid;
	end

	// Pick the middle slot of the window with the sample inserted
	always_comb begin
		med_sel = '0;
		for (int i = 0; i < MAX_WINDOW; i++) begin
			if (IDX_W'(i) == mid) begin
				med_sel = med_sel | cand[i];
			end
		end
	end

	// Window length and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			km1_q  <= swm_km1(WIN_RESET);
			fill_q <= '0;
		end else if (cfg_fire) begin
			km1_q  <= swm_km1(window_size);
			fill_q <= '0;
		end else if (accept && !full) begin
			fill_q <= fill_q + IDX_W'(1);
		end
	end

	// Output register: load on a full-window sample, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && full) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Hold the median payload
	always_ff @(posedge clk) begin
		if (accept && full) begin
			median_q <= med_sel;
		end
	end

`include "sliding_window_median_assert.svh"

	`SWM_ASSERT(a_fill_bound, fill_q <= km1_q, "fill count exceeds window length")
	`SWM_ASSERT(a_fill_matches, $countones(valid_vec) == int'(fill_q), "occupied cells differ from fill count")
	`SWM_ASSERT(a_hit_onehot, (full && !single) ? $onehot(hit_vec) : (hit_vec == '0), "oldest sample not unique")
	`SWM_ASSERT_NEXT(a_cfg_empties, cfg_fire, fill_q == '0 && valid_vec == '0, "length write did not empty window")

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench of the running-median filter: queue-fed driver, monitor and predictor.
module tb_top
	import swm_pkg::*;
();

	localparam int CYCLE_LIMIT   = 400000;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 4;
	localparam int IDLE_PERCENT  = 29;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  cfg_valid   = 1'b0;
	logic                  cfg_ready;
	logic [CFG_W-1:0]      window_size = WIN_RESET;
	logic                  in_valid    = 1'b0;
	logic                  in_ready;
	logic [DATA_WIDTH-1:0] sample      = '0;
	logic                  out_valid;
	logic                  out_ready   = 1'b0;
	logic [DATA_WIDTH-1:0] median;

	// Samples waiting to be offered, and medians predicted but not yet seen
	logic [DATA_WIDTH-1:0] sample_queue[$];
	logic [DATA_WIDTH-1:0] median_queue[$];

	// Predicted window: samples in arrival order and the same samples sorted
	logic [CFG_W-1:0]      win_cfg = WIN_RESET;
	logic [DATA_WIDTH-1:0] win_arrival[$];
	logic [DATA_WIDTH-1:0] win_sorted[$];

	bit in_fire     = 1'b0;
	bit no_idle     = 1'b0;
	bit rx_hold_req = 1'b0;
	int hold_left   = 0;
	int error_count = 0;
	int cycle_count = 0;

	sliding_window_median i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.window_size(window_size),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample     (sample),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.median     (median)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Window length in use: zero acts as one, large values saturate
	function automatic int win_len_eff(input logic [CFG_W-1:0] w);
		int k;
		k = int'(w);
		if (k == 0) begin
			k = 1;
		end else if (k > MAX_WINDOW) begin
			k = MAX_WINDOW;
		end
		return k;
	endfunction

	// Insert a sample; once the window is full, give the lower median and drop the oldest
	function automatic bit window_median_step(input logic [DATA_WIDTH-1:0] v,
		output logic [DATA_WIDTH-1:0] med);
		int k;
		int pos;
		k   = win_len_eff(win_cfg);
		pos = 0;
		med = '0;
		while (pos < win_sorted.size() && win_sorted[pos] <= v) pos++;
		win_sorted.insert(pos, v);
		win_arrival.push_back(v);
		if (win_arrival.size() < k) begin
			return 1'b0;
		end
		med = win_sorted[(k - 1) / 2];
		// remove one copy of the oldest sample only
		pos = 0;
		while (win_sorted[pos] != win_arrival[0]) pos++;
		win_sorted.delete(pos);
		void'(win_arrival.pop_front());
		return 1'b1;
	endfunction

	// Mix extremes, small repeated values and single-bit patterns into the random data
	function automatic logic [DATA_WIDTH-1:0] rand_sample();
		logic [DATA_WIDTH-1:0] one_hot;
		one_hot = DATA_WIDTH'(1) << $urandom_range(DATA_WIDTH - 1);
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2, 3, 4: return DATA_WIDTH'($urandom_range(7));
			5: return one_hot;
			6: return ~one_hot;
			default: return DATA_WIDTH'($urandom);
		endcase
	endfunction

	// Drive samples from the pending queue; hold valid and data until the transaction
	always @(negedge clk) begin
		logic                  nv;
		logic [DATA_WIDTH-1:0] ns;
		logic                  go;
		nv = in_valid;
		ns = sample;
		if (arst_n && (!in_valid || in_fire)) begin
			nv = 1'b0;
			go = no_idle || $urandom_range(99) >= IDLE_PERCENT;
			if (sample_queue.size() > 0 && go) begin
				nv = 1'b1;
				ns = sample_queue.pop_front();
			end
		end
		in_valid <= nv;
		sample   <= ns;
	end

	// Stall the result side at random, or for a long hold-off when requested
	always @(negedge clk) begin
		logic nr;
		nr = no_idle || $urandom_range(99) >= IDLE_PERCENT;
		if (hold_left > 0) begin
			nr = 1'b0;
			hold_left--;
		end else if (rx_hold_req) begin
			rx_hold_req = 1'b0;
			hold_left   = HOLD_CYCLES;
			nr          = 1'b0;
		end
		out_ready <= nr;
	end

	// Observe every transaction: apply length writes, check medians, predict new ones
	always @(posedge clk) begin
		logic [DATA_WIDTH-1:0] want;
		in_fire = 1'b0;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				win_cfg = window_size;
				win_arrival.delete();
				win_sorted.delete();
			end
			if (out_valid && out_ready) begin
				if (median_queue.size() == 0) begin
					$display("%0t: unexpected median, expected none actual %0d", $time, median);
					error_count++;
				end else begin
					want = median_queue.pop_front();
					if (median !== want) begin
						$display("%0t: median mismatch, expected %0d actual %0d",
							$time, want, median);
						error_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				in_fire = 1'b1;
				if (window_median_step(sample, want))
					median_queue.push_back(want);
			end
		end
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("sliding_window_median verification failed");
			$finish;
		end
	end

	// Wait until every sample is taken and every median has come out
	task automatic drain();
		@(posedge clk);
		while (sample_queue.size() > 0 || in_valid || median_queue.size() > 0)
			@(posedge clk);
	endtask

	// Write the window length once the filter is idle
	task automatic write_window(input logic [CFG_W-1:0] w);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_valid   <= 1'b1;
		window_size <= w;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input logic [CFG_W-1:0] w, input int count);
		write_window(w);
		repeat (count) sample_queue.push_back(rand_sample());
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: extremes and duplicates at the reset length of three
		sample_queue = '{32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'd5, 32'd5, 32'd5, 32'd9, 32'd1, 32'd5, 32'd2, 32'd2};

		// Directed: length zero acts as one
		write_window('0);
		sample_queue = '{32'h0, 32'hFFFF_FFFF, 32'd7, 32'd7, 32'd3};

		// Random: largest window with no idling on either side
		no_idle = 1'b1;
		run_phase(CFG_W'(MAX_WINDOW), 260);
		drain();
		no_idle = 1'b0;

		// Random: all-ones length saturates, then the smallest window
		run_phase('1, 200);
		run_phase(CFG_W'(1), 150);

		// Random: hold off the result side while samples keep coming
		run_phase(CFG_W'(2), 250);
		rx_hold_req = 1'b1;

		run_phase(CFG_W'(MAX_WINDOW + 1), 130);
		run_phase(CFG_W'(4), 200);

		// Random: pause the sample side until all medians are out
		run_phase(CFG_W'(16), 100);
		drain();
		repeat (100) sample_queue.push_back(rand_sample());

		run_phase(CFG_W'(33), 160);
		run_phase(CFG_W'(MAX_WINDOW - 1), 150);
		repeat (2) run_phase(CFG_W'($urandom_range(0, 127)), 120);

		drain();
		repeat (10) @(posedge clk);
		if (error_count == 0) begin
			$display("sliding_window_median verification clean");
		end else begin
			$display("sliding_window_median verification failed");
		end
		$finish;
	end

endmodule

// ===== sliding_window_median.f =====
+incdir+rtl/core
rtl/core/swm_pkg.sv
rtl/core/swm_cell.sv
rtl/core/sliding_window_median.sv
tb/tb_top.sv
